// ===== rtl/hshp_pkg.sv =====
// ----------------------------------------------------------------------------
// hshp_pkg
// shared types and constants of the heading sector haptic pulser
// ----------------------------------------------------------------------------
package hshp_pkg;

    localparam int HEADING_W     = 13;
    localparam int HEADING_LIMIT = 5760;
    localparam int AVG_W         = 17;
    localparam int FULL_TURN     = 92160;
    localparam int HALF_TURN     = 46080;
    localparam int ALPHA_W       = 8;
    localparam int THRESHOLD_W   = 10;
    localparam int DURATION_W    = 16;
    localparam int ACTIVE_W      = 4;
    localparam int CFG_INDEX_W   = 3;
    localparam int CFG_DATA_W    = 16;

    localparam int NUM_SECTORS_DEF = 16;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [ALPHA_W-1:0]     ALPHA_RST     = 8'd46;
    localparam logic [THRESHOLD_W-1:0] THRESHOLD_RST = 10'd48;
    localparam logic [DURATION_W-1:0]  ON_MS_RST     = 16'd250;
    localparam logic [DURATION_W-1:0]  PAUSE_MS_RST  = 16'd1500;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ALPHA          = 3'd0,
        REG_THRESHOLD      = 3'd1,
        REG_ON_DURATION    = 3'd2,
        REG_PAUSE_INTERVAL = 3'd3,
        REG_ALWAYS_ON      = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic [ALPHA_W-1:0]     alpha;
        logic [THRESHOLD_W-1:0] threshold;
        logic [DURATION_W-1:0]  on_ms;
        logic [DURATION_W-1:0]  pause_ms;
        logic                   always_on;
    } cfg_t;

    typedef struct packed {
        logic [ACTIVE_W-1:0] sector;
        logic                motor;
        logic                changed;
    } sector_res_t;

endpackage

// ===== rtl/hshp_smooth.sv =====
// ----------------------------------------------------------------------------
// hshp_smooth
// wrap-aware exponential average of the heading, seeded by the first sample
// ----------------------------------------------------------------------------
module hshp_smooth
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [hshp_pkg::HEADING_W-1:0]  heading,
    input  logic [hshp_pkg::ALPHA_W-1:0]    alpha,
    output logic                            in_range,
    output logic [hshp_pkg::AVG_W-1:0]      avg
);

    localparam int AVG_W  = hshp_pkg::AVG_W;
    localparam int D_W    = AVG_W + 2;
    localparam int PROD_W = D_W + hshp_pkg::ALPHA_W + 1;

    localparam logic signed [D_W-1:0]    FULL_D  = D_W'(hshp_pkg::FULL_TURN);
    localparam logic signed [D_W-1:0]    HALF_D  = D_W'(hshp_pkg::HALF_TURN);
    localparam logic signed [PROD_W-1:0] ROUND_P = PROD_W'(1 << (hshp_pkg::ALPHA_W - 1));

    logic [AVG_W-1:0]         avg_reg;
    logic [AVG_W-1:0]         avg_next;
    logic                     seeded_reg;
    logic [AVG_W-1:0]         target;
    logic signed [D_W-1:0]    diff_raw;
    logic signed [D_W-1:0]    diff_wrap;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rounded;
    logic signed [D_W-1:0]    step;
    logic signed [D_W-1:0]    sum;
    logic signed [D_W-1:0]    sum_wrap;

    assign in_range = (heading < hshp_pkg::HEADING_W'(hshp_pkg::HEADING_LIMIT));
    assign target   = {heading, 4'b0000};

    always_comb
    begin
        diff_raw = $signed(D_W'(target)) - $signed(D_W'(avg_reg));
        if (diff_raw > HALF_D)
        begin
            diff_wrap = diff_raw - FULL_D;
        end
        else if (diff_raw < -HALF_D)
        begin
            diff_wrap = diff_raw + FULL_D;
        end
        else
        begin
            diff_wrap = diff_raw;
        end

        prod    = PROD_W'($signed({1'b0, alpha})) * PROD_W'(diff_wrap);
        rounded = prod + ROUND_P;
        step    = D_W'(rounded >>> hshp_pkg::ALPHA_W);
        sum     = $signed(D_W'(avg_reg)) + step;

        if (sum >= FULL_D)
        begin
            sum_wrap = sum - FULL_D;
        end
        else if (sum < $signed(D_W'(0)))
        begin
            sum_wrap = sum + FULL_D;
        end
        else
        begin
            sum_wrap = sum;
        end

        avg_next = seeded_reg ? AVG_W'(sum_wrap) : target;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg    <= '0;
            seeded_reg <= 1'b0;
        end
        else if (fire && in_range)
        begin
            avg_reg    <= avg_next;
            seeded_reg <= 1'b1;
        end
    end

    assign avg = avg_reg;

endmodule

// ===== rtl/hshp_sector.sv =====
// ----------------------------------------------------------------------------
// hshp_sector
// sector choice with hysteresis and motor pulse timing
// ----------------------------------------------------------------------------
module hshp_sector
#(
    parameter int NUM_SECTORS = hshp_pkg::NUM_SECTORS_DEF,
    parameter int TIME_BITS   = hshp_pkg::TIME_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          fire,
    input  logic [hshp_pkg::AVG_W-1:0]    avg,
    input  logic [TIME_BITS-1:0]          now,
    input  hshp_pkg::cfg_t                cfg,
    input  logic                          clear_vib,
    output hshp_pkg::sector_res_t         res
);

    localparam int AVG_W     = hshp_pkg::AVG_W;
    localparam int SPAN      = hshp_pkg::FULL_TURN / NUM_SECTORS;
    localparam int HALF_SPAN = SPAN / 2;
    localparam int X_W       = AVG_W + 1;
    localparam int SHIFT     = 32;
    localparam longint unsigned RECIP = ((64'd1 << SHIFT) / SPAN) + 64'd1;
    localparam int RECIP_W   = $clog2(RECIP + 1);
    localparam int PROD_W    = X_W + RECIP_W;
    localparam int IDX_W     = $clog2(NUM_SECTORS + 1);
    localparam int SEC_W     = $clog2(NUM_SECTORS);
    localparam int LIMIT_W   = hshp_pkg::DURATION_W + 1;
    localparam int CMP_W     = (TIME_BITS > LIMIT_W) ? TIME_BITS : LIMIT_W;

    logic [SEC_W-1:0]     cur_reg;
    logic [SEC_W-1:0]     cur_next;
    logic                 sec_valid_reg;
    logic                 vib_reg;
    logic                 vib_next;
    logic [TIME_BITS-1:0] last_reg;
    logic [TIME_BITS-1:0] last_next;

    logic [X_W-1:0]       x;
    logic [PROD_W-1:0]    prod;
    logic [IDX_W-1:0]     idx;
    logic [AVG_W-1:0]     center;
    logic [AVG_W-1:0]     center_gap;
    logic [SEC_W-1:0]     folded;
    logic                 changed;
    logic                 vib_mid;
    logic [TIME_BITS-1:0] last_mid;
    logic [TIME_BITS-1:0] dt;
    logic [CMP_W-1:0]     dt_ext;
    logic [LIMIT_W-1:0]   limit;

    always_comb
    begin
        x          = X_W'(avg) + X_W'(HALF_SPAN);
        prod       = PROD_W'(x) * PROD_W'(RECIP);
        idx        = prod[SHIFT +: IDX_W];
        center     = AVG_W'(idx) * AVG_W'(SPAN);
        center_gap = (center > avg) ? (center - avg) : (avg - center);
        folded     = (idx == IDX_W'(NUM_SECTORS)) ? '0 : SEC_W'(idx);

        if (sec_valid_reg && (center_gap > AVG_W'({cfg.threshold, 4'b0000})))
        begin
            cur_next = cur_reg;
        end
        else
        begin
            cur_next = folded;
        end

        changed  = !sec_valid_reg || (cur_next != cur_reg);
        vib_mid  = changed ? 1'b1 : vib_reg;
        last_mid = changed ? now : last_reg;

        dt     = now - last_mid;
        dt_ext = CMP_W'(dt);
        limit  = LIMIT_W'(cfg.on_ms) + LIMIT_W'(cfg.pause_ms);

        vib_next  = vib_mid;
        last_next = last_mid;
        if (cfg.always_on ? !vib_mid : (dt_ext >= CMP_W'(limit)))
        begin
            vib_next  = 1'b1;
            last_next = now;
        end
        else if (!cfg.always_on && vib_mid && (dt_ext >= CMP_W'(cfg.on_ms)))
        begin
            vib_next = 1'b0;
        end

        res.sector  = hshp_pkg::ACTIVE_W'(cur_next);
        res.motor   = vib_next;
        res.changed = changed;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            sec_valid_reg <= 1'b0;
            vib_reg       <= 1'b0;
            last_reg      <= '0;
        end
        else if (clear_vib)
        begin
            vib_reg <= 1'b0;
        end
        else if (fire)
        begin
            cur_reg       <= cur_next;
            sec_valid_reg <= 1'b1;
            vib_reg       <= vib_next;
            last_reg      <= last_next;
        end
    end

endmodule

// ===== rtl/heading_sector_haptic_pulser_unit.sv =====
// ----------------------------------------------------------------------------
// heading_sector_haptic_pulser_unit
// smooths compass headings, picks a sector and drives its haptic motor
//
//   channel  handshake             payload
//   in       in_valid / in_stall   heading, now_ms
//   out      out_valid / out_stall active_sector, motor_on, sector_changed,
//                                  smoothed_heading
//   cfg      cfg_write             cfg_index, cfg_data
//
// three register stages: input, smoothed average, result; one request per
// cycle while out_stall is low; a request passes them in that order to out_valid
// the average multiply sets the first stage, the sector reciprocal the second
// out-of-range headings are dropped after the input stage
// out_stall backs up through the stages; in_stall rises only when all are full
// reset restores the register defaults and clears the valid flags, average and sector state
// ----------------------------------------------------------------------------
module heading_sector_haptic_pulser_unit
#(
    parameter int NUM_SECTORS = hshp_pkg::NUM_SECTORS_DEF,
    parameter int TIME_BITS   = hshp_pkg::TIME_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [hshp_pkg::HEADING_W-1:0]    heading,
    input  logic [TIME_BITS-1:0]              now_ms,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [hshp_pkg::ACTIVE_W-1:0]     active_sector,
    output logic                              motor_on,
    output logic                              sector_changed,
    output logic [hshp_pkg::HEADING_W-1:0]    smoothed_heading,
    input  logic                              cfg_write,
    input  logic [hshp_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [hshp_pkg::CFG_DATA_W-1:0]   cfg_data
);

    hshp_pkg::cfg_t                     cfg_reg;
    logic                               clear_vib;

    logic                               in_valid_reg;
    logic [hshp_pkg::HEADING_W-1:0]     heading_reg;
    logic [TIME_BITS-1:0]               now_reg;
    logic                               mid_valid_reg;
    logic [TIME_BITS-1:0]               mid_now_reg;
    logic                               out_valid_reg;
    hshp_pkg::sector_res_t              res_reg;
    logic [hshp_pkg::HEADING_W-1:0]     smoothed_reg;

    logic                               out_adv;
    logic                               mid_free;
    logic                               in_free;
    logic                               s1_fire;
    logic                               s2_fire;
    logic                               in_range;
    logic [hshp_pkg::AVG_W-1:0]         avg;
    hshp_pkg::sector_res_t              res;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alpha     <= hshp_pkg::ALPHA_RST;
            cfg_reg.threshold <= hshp_pkg::THRESHOLD_RST;
            cfg_reg.on_ms     <= hshp_pkg::ON_MS_RST;
            cfg_reg.pause_ms  <= hshp_pkg::PAUSE_MS_RST;
            cfg_reg.always_on <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                hshp_pkg::REG_ALPHA:
                begin
                    cfg_reg.alpha <= cfg_data[hshp_pkg::ALPHA_W-1:0];
                end
                hshp_pkg::REG_THRESHOLD:
                begin
                    cfg_reg.threshold <= cfg_data[hshp_pkg::THRESHOLD_W-1:0];
                end
                hshp_pkg::REG_ON_DURATION:
                begin
                    cfg_reg.on_ms <= cfg_data[hshp_pkg::DURATION_W-1:0];
                end
                hshp_pkg::REG_PAUSE_INTERVAL:
                begin
                    cfg_reg.pause_ms <= cfg_data[hshp_pkg::DURATION_W-1:0];
                end
                hshp_pkg::REG_ALWAYS_ON:
                begin
                    cfg_reg.always_on <= cfg_data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign clear_vib = cfg_write && (cfg_index == hshp_pkg::REG_ALWAYS_ON) && cfg_data[0];

    // flow control
    assign out_adv  = !out_valid_reg || !out_stall;
    assign mid_free = !mid_valid_reg || out_adv;
    assign in_free  = !in_valid_reg || mid_free;
    assign s1_fire  = in_valid_reg && mid_free;
    assign s2_fire  = mid_valid_reg && out_adv;
    assign in_stall = !in_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_free)
            begin
                in_valid_reg <= in_valid;
            end
            if (mid_free)
            begin
                mid_valid_reg <= s1_fire && in_range;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_free)
        begin
            heading_reg <= heading;
            now_reg     <= now_ms;
        end
        if (s1_fire)
        begin
            mid_now_reg <= now_reg;
        end
        if (s2_fire)
        begin
            res_reg      <= res;
            smoothed_reg <= avg[hshp_pkg::AVG_W-1:4];
        end
    end

    hshp_smooth u_smooth
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (s1_fire),
        .heading  (heading_reg),
        .alpha    (cfg_reg.alpha),
        .in_range (in_range),
        .avg      (avg)
    );

    hshp_sector
    #(
        .NUM_SECTORS (NUM_SECTORS),
        .TIME_BITS   (TIME_BITS)
    )
    u_sector
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (s2_fire),
        .avg       (avg),
        .now       (mid_now_reg),
        .cfg       (cfg_reg),
        .clear_vib (clear_vib),
        .res       (res)
    );

    assign out_valid        = out_valid_reg;
    assign active_sector    = res_reg.sector;
    assign motor_on         = res_reg.motor;
    assign sector_changed   = res_reg.changed;
    assign smoothed_heading = smoothed_reg;

endmodule
